[design/assert_macros.svh]
// Assertion macros shared by the design files.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KOP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define KOP_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define KOP_ASSERT(lbl, clk, rstn, prop, msg)
`define KOP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[design/kop_pkg.sv]
// Package for the Kepler orbit position core: widths, element ROM, CORDIC
// arctangents, sequencer types. No dependencies.
package kop_pkg;

    localparam int NUM_BODIES_DEF = 5;
    localparam int WORDS_PER_BODY = 6;
    localparam int ROM_DEPTH      = 30;
    localparam int ROM_AW         = 5;
    localparam int BODY_W         = 3;
    localparam int TIME_W         = 40;
    localparam int POS_W          = 32;
    localparam int LIM_W          = 5;
    localparam int CNT_W          = 7;
    localparam int CORDIC_STEPS   = 30;
    localparam int SQRT_STEPS     = 32;
    localparam int DIV_STEPS      = 64;
    localparam int MN_STEPS       = 56;
    localparam int MUL_W          = 36;
    localparam int PROD_W         = 72;
    localparam int CR_W           = 34;
    localparam int EA_W           = 33;
    localparam int DVD_W          = 64;
    localparam int DVS_W          = 35;
    localparam int SQ_W           = 64;
    localparam int MN_W           = 56;
    localparam int SAT_W          = 42;

    localparam logic [LIM_W-1:0] LIMIT_RESET     = 5'd30;
    localparam logic [CR_W-1:0]  CORDIC_GAIN     = 34'd652032874;
    localparam logic [31:0]      INV_TWO_PI_Q32  = 32'd683565276;
    localparam logic [31:0]      MEAN_MOTION_K40 = 32'd3010242050;
    localparam logic [31:0]      ECC_SWITCH      = 32'd1717986919;

    localparam logic [31:0] ELEMENT_ROM [ROM_DEPTH] = '{
        32'd742492471,  32'd168792215,  32'd126307830,  32'd959328667,
        32'd878320812,  32'd1804244178, 32'd744317832,  32'd493706491,
        32'd415585808,  32'd2062896653, 32'd3703335551, 32'd961714760,
        32'd633964016,  32'd191555541,  32'd85123866,   32'd1238501542,
        32'd1803886264, 32'd1824645273, 32'd716856885,  32'd551688549,
        32'd154988667,  32'd2026508736, 32'd2958397334, 32'd1725025893,
        32'd640218563,  32'd493921239,  32'd65856165,   32'd3096552116,
        32'd1733735132, 32'd240160255
    };

    typedef enum logic [4:0] {
        S_IDLE, S_SQ_SET, S_SQ_RUN, S_MUL_A15, S_DIV_SET, S_DIV_RUN, S_MNT_RUN,
        S_MANOM, S_COR_SET, S_COR_RUN, S_NT_M1, S_NT_M2, S_NT_M3, S_NT_UPD,
        S_X1, S_X2, S_AB, S_YO1, S_YO2, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6,
        S_R7, S_R8, S_R9, S_R10, S_R11, S_R12
    } state_t;

    typedef enum logic [2:0] {
        CJ_NEWTON, CJ_FINAL, CJ_PERI, CJ_NODE, CJ_INCL
    } cjob_t;

    typedef enum logic {SJ_AXIS, SJ_MINOR} sjob_t;
    typedef enum logic {DJ_MOTION, DJ_NEWTON} djob_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:    atan_turn = 32'd536870912;
            5'd1:    atan_turn = 32'd316933407;
            5'd2:    atan_turn = 32'd167458907;
            5'd3:    atan_turn = 32'd85004756;
            5'd4:    atan_turn = 32'd42667331;
            5'd5:    atan_turn = 32'd21354465;
            5'd6:    atan_turn = 32'd10679838;
            5'd7:    atan_turn = 32'd5340245;
            5'd8:    atan_turn = 32'd2670163;
            5'd9:    atan_turn = 32'd1335087;
            5'd10:   atan_turn = 32'd667544;
            default: atan_turn = INV_TWO_PI_Q32 >> i;
        endcase
    endfunction

    function automatic logic [31:0] rom_word(input logic [BODY_W-1:0] body,
                                             input logic [2:0] k);
        logic [5:0] idx;
        idx = 6'(body) * 6'(WORDS_PER_BODY) + 6'(k);
        if (idx < 6'(ROM_DEPTH))
            rom_word = ELEMENT_ROM[idx[ROM_AW-1:0]];
        else
            rom_word = '0;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(32'sh7FFF_FFFF))
            sat_pos = 32'sh7FFF_FFFF;
        else if (v < -(SAT_W'(33'sd2147483648)))
            sat_pos = 32'sh8000_0000;
        else
            sat_pos = v[POS_W-1:0];
    endfunction

endpackage

[design/kepler_orbit_position_core.sv]
// Kepler orbit position core: mean anomaly, Newton solve of Kepler's equation,
// orbit-plane rotation to heliocentric x, y, z. Depends on kop_pkg and
// assert_macros.svh.
//
// Usage:
//   A word is accepted at a clock edge with start high and busy low. For a known
//   body busy stays high until the result is ready; no new word is taken meanwhile.
//   The result word (pos_x, pos_y, pos_z, body_valid) is shown for exactly one
//   cycle with done high; it must be taken then, the receiver cannot stall.
//   Write iteration_limit with cfg_we/cfg_wdata while the core is idle; the core does not enforce it.
// Sequence:
//   Unknown body: done rises in the cycle after accept, busy never rises.
//   Known body: the result follows N Newton iterations (N at most
//   iteration_limit). Each iteration is a 30-step CORDIC, three multiplies
//   and a 64-step restoring divide on the shared divider; the rest is a
//   32-step square root twice, a 64-step divide, a 56-step shift-add
//   multiply, four CORDIC passes and one 36x36 multiplier used at most
//   once per cycle.
//   No new word is taken until the last is done; the next word can be taken
//   in the cycle that done is high.
// Reset:
//   Async active-low reset returns to idle and sets iteration_limit to 30.
`include "assert_macros.svh"

module kepler_orbit_position_core #(
    parameter int NUM_BODIES = kop_pkg::NUM_BODIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [kop_pkg::BODY_W-1:0]          body_index,
    input  logic signed [kop_pkg::TIME_W-1:0]   days_since_epoch,
    input  logic                                cfg_we,
    input  logic [kop_pkg::LIM_W-1:0]           cfg_wdata,
    output logic                                done,
    output logic signed [kop_pkg::POS_W-1:0]    pos_x,
    output logic signed [kop_pkg::POS_W-1:0]    pos_y,
    output logic signed [kop_pkg::POS_W-1:0]    pos_z,
    output logic                                body_valid
);
    import kop_pkg::*;

    localparam logic signed [EA_W-1:0] HALF_EA = 33'sd2147483648;
    localparam logic signed [65:0]     HALF_66 = 66'sd2147483648;

    state_t state_reg, state_next;
    cjob_t  cjob_reg, cjob_next;
    sjob_t  sjob_reg, sjob_next;
    djob_t  djob_reg, djob_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [LIM_W-1:0] it_reg, it_next;
    logic [LIM_W-1:0] limit_reg;
    logic done_reg, done_next;
    logic valid_reg, valid_next;
    logic flip_reg, flip_next;
    logic sign_reg, sign_next;

    logic [BODY_W-1:0]          body_reg, body_next;
    logic signed [TIME_W-1:0]   t_reg, t_next;
    logic [31:0]                a_reg, a_next, e_reg, e_next;
    logic signed [31:0]         m_reg, m_next;
    logic signed [EA_W-1:0]     ea_reg, ea_next;
    logic signed [MUL_W-1:0]    f_reg, f_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next, acc_reg, acc_next;
    logic [SQ_W-1:0]            sq_v_reg, sq_v_next, sq_r_reg, sq_r_next;
    logic [DVD_W-1:0]           dvd_reg, dvd_next;
    logic [DVS_W-1:0]           dvs_reg, dvs_next;
    logic [DVS_W:0]             rem_reg, rem_next;
    logic [MN_W-1:0]            nsh_reg, nsh_next, tsh_reg, tsh_next, mn_reg, mn_next;
    logic signed [CR_W-1:0]     cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic signed [31:0]         c_reg, c_next, s_reg, s_next;
    logic signed [31:0]         co_reg, co_next, so_reg, so_next;
    logic signed [31:0]         cn_reg, cn_next, sn_reg, sn_next;
    logic signed [31:0]         ci_reg, ci_next, si_reg, si_next;
    logic signed [MUL_W-1:0]    xo_reg, xo_next, yo_reg, yo_next;
    logic signed [MUL_W-1:0]    xp_reg, xp_next, yp_reg, yp_next, yc_reg, yc_next;
    logic signed [POS_W-1:0]    px_reg, px_next, py_reg, py_next, pz_reg, pz_next;

    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic                       mul_en;

    // shared step units
    logic [CNT_W-1:0]           sq_sh;
    logic [SQ_W-1:0]            sq_bit, sq_sum;
    logic                       sq_ge;
    logic [DVS_W:0]             div_rsh;
    logic                       div_ge;
    logic signed [CR_W-1:0]     cor_xs, cor_ys, cor_at, cor_xn, cor_yn, cor_zn;
    logic signed [CR_W-1:0]     cor_zin, cor_cx, cor_cy;
    logic [31:0]                cor_ang;
    logic signed [PROD_W-1:0]   rot_diff, rot_sum;
    logic signed [MUL_W-1:0]    fp_raw, f_abs;
    logic signed [65:0]         ea_upd;
    logic [MN_W-1:0]            t_ext;

    assign sq_sh  = CNT_W'(62) - {cnt_reg[CNT_W-2:0], 1'b0};
    assign sq_bit = SQ_W'(1) << sq_sh;
    assign sq_sum = sq_r_reg + sq_bit;
    assign sq_ge  = sq_v_reg >= sq_sum;

    assign div_rsh = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign div_ge  = div_rsh >= {1'b0, dvs_reg};

    assign cor_xs = cx_reg >>> cnt_reg[4:0];
    assign cor_ys = cy_reg >>> cnt_reg[4:0];
    assign cor_at = signed'({2'b00, atan_turn(cnt_reg[4:0])});
    assign cor_xn = !cz_reg[CR_W-1] ? cx_reg - cor_ys : cx_reg + cor_ys;
    assign cor_yn = !cz_reg[CR_W-1] ? cy_reg + cor_xs : cy_reg - cor_xs;
    assign cor_zn = !cz_reg[CR_W-1] ? cz_reg - cor_at : cz_reg + cor_at;
    assign cor_cx = flip_reg ? -cor_xn : cor_xn;
    assign cor_cy = flip_reg ? -cor_yn : cor_yn;
    assign cor_zin = signed'({{2{cor_ang[31]}}, cor_ang});

    assign rot_diff = acc_reg - prod_reg;
    assign rot_sum  = acc_reg + prod_reg;
    assign fp_raw   = 36'sd1073741824 - signed'(prod_reg[66:31]);
    assign f_abs    = f_reg[MUL_W-1] ? -f_reg : f_reg;
    assign ea_upd   = sign_reg ? 66'(ea_reg) + signed'({2'b00, dvd_reg})
                               : 66'(ea_reg) - signed'({2'b00, dvd_reg});
    assign t_ext    = {{(MN_W-TIME_W){t_reg[TIME_W-1]}}, t_reg};

    always_comb
    begin
        case (cjob_reg)
            CJ_PERI: cor_ang = rom_word(body_reg, 3'd4);
            CJ_NODE: cor_ang = rom_word(body_reg, 3'd3);
            CJ_INCL: cor_ang = rom_word(body_reg, 3'd2);
            default: cor_ang = ea_reg[31:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cjob_next  = cjob_reg;
        sjob_next  = sjob_reg;
        djob_next  = djob_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        done_next  = 1'b0;
        valid_next = valid_reg;
        flip_next  = flip_reg;
        sign_next  = sign_reg;
        body_next  = body_reg;
        t_next     = t_reg;
        a_next     = a_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        ea_next    = ea_reg;
        f_next     = f_reg;
        acc_next   = acc_reg;
        sq_v_next  = sq_v_reg;
        sq_r_next  = sq_r_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        nsh_next   = nsh_reg;
        tsh_next   = tsh_reg;
        mn_next    = mn_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        co_next    = co_reg;
        so_next    = so_reg;
        cn_next    = cn_reg;
        sn_next    = sn_reg;
        ci_next    = ci_reg;
        si_next    = si_reg;
        xo_next    = xo_reg;
        yo_next    = yo_reg;
        xp_next    = xp_reg;
        yp_next    = yp_reg;
        yc_next    = yc_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        pz_next    = pz_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    body_next = body_index;
                    t_next    = days_since_epoch;
                    if (int'(body_index) < NUM_BODIES)
                    begin
                        a_next     = rom_word(body_index, 3'd0);
                        e_next     = rom_word(body_index, 3'd1);
                        sjob_next  = SJ_AXIS;
                        state_next = S_SQ_SET;
                    end
                    else
                    begin
                        px_next    = '0;
                        py_next    = '0;
                        pz_next    = '0;
                        valid_next = 1'b0;
                        done_next  = 1'b1;
                    end
                end
            end

            S_SQ_SET:
            begin
                if (sjob_reg == SJ_AXIS)
                    sq_v_next = {4'b0, a_reg, 28'b0};
                else
                    sq_v_next = (SQ_W'(32'h8000_0000) - {23'b0, prod_reg[PROD_W-1:31]}) << 31;
                sq_r_next  = '0;
                cnt_next   = '0;
                state_next = S_SQ_RUN;
            end

            S_SQ_RUN:
            begin
                if (sq_ge)
                begin
                    sq_v_next = sq_v_reg - sq_sum;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit;
                end
                else
                    sq_r_next = sq_r_reg >> 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = (sjob_reg == SJ_AXIS) ? S_MUL_A15 : S_AB;
            end

            S_MUL_A15:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, a_reg});
                mul_b      = signed'({4'b0, sq_r_reg[31:0]});
                djob_next  = DJ_MOTION;
                state_next = S_DIV_SET;
            end

            S_DIV_SET:
            begin
                rem_next = '0;
                cnt_next = '0;
                if (djob_reg == DJ_MOTION)
                begin
                    dvs_next = prod_reg[62:28];
                    dvd_next = {4'b0, MEAN_MOTION_K40, 28'b0};
                    if (prod_reg[62:28] == '0)
                    begin
                        nsh_next   = '0;
                        tsh_next   = t_ext;
                        mn_next    = '0;
                        state_next = S_MNT_RUN;
                    end
                    else
                        state_next = S_DIV_RUN;
                end
                else
                begin
                    dvs_next   = (fp_raw < 36'sd1) ? DVS_W'(1) : fp_raw[DVS_W-1:0];
                    dvd_next   = {f_abs[33:0], 30'b0};
                    sign_next  = f_reg[MUL_W-1];
                    state_next = S_DIV_RUN;
                end
            end

            S_DIV_RUN:
            begin
                if (div_ge)
                begin
                    rem_next = div_rsh - {1'b0, dvs_reg};
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_rsh;
                    dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (djob_reg == DJ_MOTION)
                    begin
                        nsh_next   = dvd_next[MN_W-1:0];
                        tsh_next   = t_ext;
                        mn_next    = '0;
                        cnt_next   = '0;
                        state_next = S_MNT_RUN;
                    end
                    else
                        state_next = S_NT_UPD;
                end
            end

            S_MNT_RUN:
            begin
                if (nsh_reg[0])
                    mn_next = mn_reg + tsh_reg;
                nsh_next = nsh_reg >> 1;
                tsh_next = tsh_reg << 1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MN_STEPS - 1))
                    state_next = S_MANOM;
            end

            S_MANOM:
            begin
                m_next = signed'(rom_word(body_reg, 3'd5) + mn_reg[55:24]);
                if (e_reg < ECC_SWITCH)
                    ea_next = EA_W'(signed'(rom_word(body_reg, 3'd5) + mn_reg[55:24]));
                else
                    ea_next = HALF_EA;
                it_next    = '0;
                cjob_next  = (limit_reg == '0) ? CJ_FINAL : CJ_NEWTON;
                state_next = S_COR_SET;
            end

            S_COR_SET:
            begin
                cx_next   = signed'(CORDIC_GAIN);
                cy_next   = '0;
                flip_next = 1'b0;
                cz_next   = cor_zin;
                if (cor_zin > 34'sd1073741824)
                begin
                    cz_next   = cor_zin - 34'sd2147483648;
                    flip_next = 1'b1;
                end
                else if (cor_zin < -34'sd1073741824)
                begin
                    cz_next   = cor_zin + 34'sd2147483648;
                    flip_next = 1'b1;
                end
                cnt_next   = '0;
                state_next = S_COR_RUN;
            end

            S_COR_RUN:
            begin
                cx_next  = cor_xn;
                cy_next  = cor_yn;
                cz_next  = cor_zn;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    case (cjob_reg)
                        CJ_PERI:
                        begin
                            co_next    = cor_cx[31:0];
                            so_next    = cor_cy[31:0];
                            cjob_next  = CJ_NODE;
                            state_next = S_COR_SET;
                        end
                        CJ_NODE:
                        begin
                            cn_next    = cor_cx[31:0];
                            sn_next    = cor_cy[31:0];
                            cjob_next  = CJ_INCL;
                            state_next = S_COR_SET;
                        end
                        CJ_INCL:
                        begin
                            ci_next    = cor_cx[31:0];
                            si_next    = cor_cy[31:0];
                            state_next = S_R1;
                        end
                        CJ_FINAL:
                        begin
                            c_next     = cor_cx[31:0];
                            s_next     = cor_cy[31:0];
                            state_next = S_X1;
                        end
                        default:
                        begin
                            c_next     = cor_cx[31:0];
                            s_next     = cor_cy[31:0];
                            state_next = S_NT_M1;
                        end
                    endcase
                end
            end

            S_NT_M1:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, e_reg});
                mul_b      = MUL_W'(s_reg);
                state_next = S_NT_M2;
            end

            S_NT_M2:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'(prod_reg[66:31]);
                mul_b      = signed'({4'b0, INV_TWO_PI_Q32});
                state_next = S_NT_M3;
            end

            S_NT_M3:
            begin
                f_next     = MUL_W'(ea_reg) - signed'(prod_reg[65:30]) - MUL_W'(m_reg);
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, e_reg});
                mul_b      = MUL_W'(c_reg);
                djob_next  = DJ_NEWTON;
                state_next = S_DIV_SET;
            end

            S_NT_UPD:
            begin
                if (ea_upd > HALF_66)
                    ea_next = HALF_EA;
                else if (ea_upd < -HALF_66)
                    ea_next = -HALF_EA;
                else
                    ea_next = ea_upd[EA_W-1:0];
                it_next = it_reg + LIM_W'(1);
                if (dvd_reg == '0 || (it_reg + LIM_W'(1)) == limit_reg)
                    cjob_next = CJ_FINAL;
                else
                    cjob_next = CJ_NEWTON;
                state_next = S_COR_SET;
            end

            S_X1:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, a_reg});
                mul_b      = MUL_W'(c_reg) - signed'({5'b0, e_reg[31:1]});
                state_next = S_X2;
            end

            S_X2:
            begin
                xo_next    = signed'(prod_reg[65:30]);
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, e_reg});
                mul_b      = signed'({4'b0, e_reg});
                sjob_next  = SJ_MINOR;
                state_next = S_SQ_SET;
            end

            S_AB:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'({4'b0, a_reg});
                mul_b      = signed'({4'b0, sq_r_reg[31:0]});
                state_next = S_YO1;
            end

            S_YO1:
            begin
                mul_en     = 1'b1;
                mul_a      = signed'(prod_reg[66:31]);
                mul_b      = MUL_W'(s_reg);
                state_next = S_YO2;
            end

            S_YO2:
            begin
                yo_next    = signed'(prod_reg[65:30]);
                cjob_next  = CJ_PERI;
                state_next = S_COR_SET;
            end

            S_R1:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(co_reg);
                mul_b      = xo_reg;
                state_next = S_R2;
            end

            S_R2:
            begin
                acc_next   = prod_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(so_reg);
                mul_b      = yo_reg;
                state_next = S_R3;
            end

            S_R3:
            begin
                xp_next    = signed'(rot_diff[65:30]);
                mul_en     = 1'b1;
                mul_a      = MUL_W'(so_reg);
                mul_b      = xo_reg;
                state_next = S_R4;
            end

            S_R4:
            begin
                acc_next   = prod_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(co_reg);
                mul_b      = yo_reg;
                state_next = S_R5;
            end

            S_R5:
            begin
                yp_next    = signed'(rot_sum[65:30]);
                state_next = S_R6;
            end

            S_R6:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(ci_reg);
                mul_b      = yp_reg;
                state_next = S_R7;
            end

            S_R7:
            begin
                yc_next    = signed'(prod_reg[65:30]);
                mul_en     = 1'b1;
                mul_a      = MUL_W'(si_reg);
                mul_b      = yp_reg;
                state_next = S_R8;
            end

            S_R8:
            begin
                pz_next    = sat_pos(signed'(prod_reg[PROD_W-1:30]));
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cn_reg);
                mul_b      = xp_reg;
                state_next = S_R9;
            end

            S_R9:
            begin
                acc_next   = prod_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(sn_reg);
                mul_b      = yc_reg;
                state_next = S_R10;
            end

            S_R10:
            begin
                px_next    = sat_pos(signed'(rot_diff[PROD_W-1:30]));
                mul_en     = 1'b1;
                mul_a      = MUL_W'(sn_reg);
                mul_b      = xp_reg;
                state_next = S_R11;
            end

            S_R11:
            begin
                acc_next   = prod_reg;
                mul_en     = 1'b1;
                mul_a      = MUL_W'(cn_reg);
                mul_b      = yc_reg;
                state_next = S_R12;
            end

            S_R12:
            begin
                py_next    = sat_pos(signed'(rot_sum[PROD_W-1:30]));
                valid_next = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = mul_en ? mul_a * mul_b : prod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cjob_reg  <= CJ_NEWTON;
            sjob_reg  <= SJ_AXIS;
            djob_reg  <= DJ_MOTION;
            cnt_reg   <= '0;
            it_reg    <= '0;
            limit_reg <= LIMIT_RESET;
            done_reg  <= 1'b0;
            valid_reg <= 1'b0;
            flip_reg  <= 1'b0;
            sign_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cjob_reg  <= cjob_next;
            sjob_reg  <= sjob_next;
            djob_reg  <= djob_next;
            cnt_reg   <= cnt_next;
            it_reg    <= it_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            flip_reg  <= flip_next;
            sign_reg  <= sign_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
        t_reg    <= t_next;
        a_reg    <= a_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        ea_reg   <= ea_next;
        f_reg    <= f_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sq_v_reg <= sq_v_next;
        sq_r_reg <= sq_r_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
        nsh_reg  <= nsh_next;
        tsh_reg  <= tsh_next;
        mn_reg   <= mn_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        co_reg   <= co_next;
        so_reg   <= so_next;
        cn_reg   <= cn_next;
        sn_reg   <= sn_next;
        ci_reg   <= ci_next;
        si_reg   <= si_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
        xp_reg   <= xp_next;
        yp_reg   <= yp_next;
        yc_reg   <= yc_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pz_reg   <= pz_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign pos_x      = px_reg;
    assign pos_y      = py_reg;
    assign pos_z      = pz_reg;
    assign body_valid = valid_reg;

    `KOP_NEVER(a_done_not_busy, clk, rst_n, done && busy, "result word while busy")
    `KOP_ASSERT(a_invalid_zero, clk, rst_n, (done && !body_valid) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0), "unknown body with nonzero position")
    `KOP_ASSERT(a_accept_busy, clk, rst_n, (start && !busy && (int'(body_index) < NUM_BODIES)) |=> busy, "known body accepted but core idle")
    `KOP_ASSERT(a_iter_bound, clk, rst_n, (state_reg == S_NT_UPD) |-> (it_reg < limit_reg), "Newton iteration beyond limit")
    `KOP_ASSERT(a_cordic_cnt, clk, rst_n, (state_reg == S_COR_RUN) |-> (cnt_reg < CNT_W'(CORDIC_STEPS)), "CORDIC step count overrun")

endmodule
